// ===== rtl/hss_pkg.sv =====
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types and constants of the harmony search step engine.
// ----------------------------------------------------------------------------
package hss_pkg;

  localparam int NUM_HARMONIES_DEF = 10;
  localparam int NUM_VARIABLES_DEF = 5;

  localparam int FIT_W = 33;
  localparam int SQ_W  = 31;
  localparam int VAL_W = 16;
  localparam int RND_W = 11;
  localparam int RATE_W = 16;

  localparam logic [FIT_W-1:0]  FIT_MAX = '1;
  localparam logic [RATE_W-1:0] CONSIDER_RATE_RST = 16'd62259;
  localparam logic [RATE_W-1:0] PITCH_RATE_RST    = 16'd45875;

  localparam logic CFG_CONSIDER = 1'b0;
  localparam logic CFG_PITCH    = 1'b1;

  typedef enum logic [1:0] {
    K_LOAD      = 2'd0,
    K_IMPROVISE = 2'd1,
    K_QUERY     = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RK_LOAD   = 2'd0,
    RK_BUILT  = 2'd1,
    RK_FINISH = 2'd2,
    RK_BEST   = 2'd3
  } rkind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_SUM,
    S_LD_OUT,
    S_IM_VAL,
    S_IM_SQ,
    S_IM_ACC,
    S_SCAN,
    S_COPY,
    S_FIN,
    S_QSCAN,
    S_QRD,
    S_QOUT
  } state_t;

endpackage

// ===== rtl/harmony_search_step.sv =====
// ----------------------------------------------------------------------------
// harmony_search_step
// Harmony search engine for the sphere function: loads memory elements,
// improvises a new harmony one variable per item and reports the best entry.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in_     | input     | in_valid / in_ready | kind, load, draw and step fields
//  out_    | output    | out_valid/out_ready | one result item per transfer
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (16 bit)
//
//  Load: a valid element is written, then the entry's variables are read back
//  through the single read port of the store and their squares are summed.
//  Improvise: the last variable adds a fitness memory scan, a copy on
//  replacement and the finish result. Query: fitness scan, then best entry read.
//  Reset (rst_n, synchronous) restores the rates; memories are not cleared.
//  A stalled out_ready holds the engine in its emitting state.
//
module harmony_search_step #(
  parameter int NUM_HARMONIES = hss_pkg::NUM_HARMONIES_DEF,
  parameter int NUM_VARIABLES = hss_pkg::NUM_VARIABLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [3:0]          in_load_entry,
  input  logic [2:0]          in_load_variable,
  input  logic signed [15:0]  in_load_value,
  input  logic [15:0]         in_consider_draw,
  input  logic [3:0]          in_pick_entry,
  input  logic signed [10:0]  in_fresh_value,
  input  logic [15:0]         in_pitch_draw,
  input  logic signed [10:0]  in_pitch_step,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_result_kind,
  output logic                out_replaced,
  output logic [3:0]          out_entry_index,
  output logic [32:0]         out_fitness,
  output logic signed [15:0]  out_element_value,
  output logic [2:0]          out_element_position,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int EW    = $clog2(NUM_HARMONIES);
  localparam int PW    = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
  localparam int MAXN  = (NUM_HARMONIES > NUM_VARIABLES) ? NUM_HARMONIES : NUM_VARIABLES;
  localparam int KW    = $clog2(MAXN + 1);
  localparam int DEPTH = NUM_HARMONIES * NUM_VARIABLES;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = hss_pkg::FIT_W;
  localparam int SW    = hss_pkg::SQ_W;

  function automatic logic [AW-1:0] st_addr(logic [EW-1:0] e, logic [PW-1:0] p);
    return AW'(e) * AW'(NUM_VARIABLES) + AW'(p);
  endfunction

  function automatic logic [FW-1:0] fit_add(logic [FW-1:0] a, logic [SW-1:0] b);
    logic [FW:0] s;
    s = {1'b0, a} + (FW+1)'(b);
    return (s > {1'b0, hss_pkg::FIT_MAX}) ? hss_pkg::FIT_MAX : s[FW-1:0];
  endfunction

  function automatic logic signed [15:0] pitch_add(logic signed [15:0] b,
                                                   logic signed [10:0] s);
    logic signed [16:0] t;
    t = 17'(b) + 17'(s);
    if (t > $signed(17'd32767)) return 16'sh7FFF;
    if (t < $signed(-17'sd32768)) return 16'sh8000;
    return t[15:0];
  endfunction

  // memories
  logic signed [15:0] st_mem [DEPTH];
  logic [FW-1:0]      ef_mem [NUM_HARMONIES];
  logic signed [15:0] st_rdata_r;
  logic [FW-1:0]      ef_rdata_r;

  logic               st_re, st_we, ef_re, ef_we, pipe_re;
  logic [AW-1:0]      st_raddr, st_waddr;
  logic signed [15:0] st_wdata;
  logic [EW-1:0]      ef_raddr, ef_waddr;
  logic [FW-1:0]      ef_wdata;

  // control
  hss_pkg::state_t    state_r, state_nxt;
  logic [15:0]        cons_r, pitch_r;
  logic [PW-1:0]      bp_r;
  logic               out_valid_r;
  logic               in_acc, out_free, ld_ok, scan_hit, pos_last;
  logic [EW-1:0]      pick_sat;

  // datapath
  logic [3:0]         lde_r;
  logic [2:0]         ldp_r;
  logic               ld_ok_r;
  logic [EW-1:0]      ent_r;
  logic [PW-1:0]      pos_r;
  logic signed [15:0] val_r;
  logic signed [10:0] fresh_r, step_r;
  logic               use_mem_r, use_pitch_r;
  logic [KW-1:0]      iss_r, rd_k_r, acc_n_r;
  logic               rd_v_r, sq_v_r;
  logic [SW-1:0]      sq_r;
  logic [FW-1:0]      acc_r, new_fit_r, best_fit_r;
  logic [EW-1:0]      best_idx_r;
  logic               found_r;
  logic signed [15:0] nh_r [NUM_VARIABLES];
  logic signed [15:0] sq_in, base_v;
  logic signed [31:0] prod;

  // output register
  logic               out_load;
  logic [1:0]         o_kind, out_result_kind_r;
  logic               o_rep, out_replaced_r, o_last, out_last_r;
  logic [3:0]         o_idx, out_entry_index_r;
  logic [FW-1:0]      o_fit, out_fitness_r;
  logic signed [15:0] o_val, out_element_value_r;
  logic [2:0]         o_pos, out_element_position_r;

  assign in_ready  = (state_r == hss_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign ld_ok     = (32'(in_load_entry) < NUM_HARMONIES) &&
                     (32'(in_load_variable) < NUM_VARIABLES);
  assign pick_sat  = (32'(in_pick_entry) >= NUM_HARMONIES) ? EW'(NUM_HARMONIES - 1)
                                                            : EW'(in_pick_entry);
  assign scan_hit  = rd_v_r && (new_fit_r < ef_rdata_r);
  assign pos_last  = (pos_r == PW'(NUM_VARIABLES - 1));
  assign sq_in     = (state_r == hss_pkg::S_IM_SQ) ? val_r : st_rdata_r;
  assign prod      = 32'(sq_in) * 32'(sq_in);
  assign base_v    = use_mem_r ? st_rdata_r : 16'(fresh_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hss_pkg::S_IDLE: begin
        if (in_acc) begin
          priority if (in_kind == hss_pkg::K_LOAD) begin
            state_nxt = ld_ok ? hss_pkg::S_LD_SUM : hss_pkg::S_LD_OUT;
          end else if (in_kind == hss_pkg::K_IMPROVISE) begin
            state_nxt = hss_pkg::S_IM_VAL;
          end else if (in_kind == hss_pkg::K_QUERY) begin
            state_nxt = hss_pkg::S_QSCAN;
          end else begin
            state_nxt = hss_pkg::S_IDLE;
          end
        end
      end
      hss_pkg::S_LD_SUM: if (acc_n_r == KW'(NUM_VARIABLES)) state_nxt = hss_pkg::S_LD_OUT;
      hss_pkg::S_LD_OUT: if (out_free) state_nxt = hss_pkg::S_IDLE;
      hss_pkg::S_IM_VAL: state_nxt = hss_pkg::S_IM_SQ;
      hss_pkg::S_IM_SQ:  if (out_free) state_nxt = hss_pkg::S_IM_ACC;
      hss_pkg::S_IM_ACC: state_nxt = pos_last ? hss_pkg::S_SCAN : hss_pkg::S_IDLE;
      hss_pkg::S_SCAN: begin
        priority if (scan_hit) begin
          state_nxt = hss_pkg::S_COPY;
        end else if (rd_v_r && rd_k_r == KW'(NUM_HARMONIES - 1)) begin
          state_nxt = hss_pkg::S_FIN;
        end
      end
      hss_pkg::S_COPY: if (iss_r == KW'(NUM_VARIABLES - 1)) state_nxt = hss_pkg::S_FIN;
      hss_pkg::S_FIN:  if (out_free) state_nxt = hss_pkg::S_IDLE;
      hss_pkg::S_QSCAN: begin
        if (rd_v_r && rd_k_r == KW'(NUM_HARMONIES - 1)) state_nxt = hss_pkg::S_QRD;
      end
      hss_pkg::S_QRD: state_nxt = hss_pkg::S_QOUT;
      hss_pkg::S_QOUT: begin
        if (out_free) begin
          state_nxt = (iss_r == KW'(NUM_VARIABLES - 1)) ? hss_pkg::S_IDLE : hss_pkg::S_QRD;
        end
      end
      default: state_nxt = hss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    st_re    = 1'b0;
    st_raddr = '0;
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    ef_re    = 1'b0;
    ef_raddr = '0;
    ef_we    = 1'b0;
    ef_waddr = ent_r;
    ef_wdata = acc_r;
    pipe_re  = 1'b0;
    out_load = 1'b0;
    o_kind   = hss_pkg::RK_LOAD;
    o_rep    = 1'b0;
    o_idx    = '0;
    o_fit    = '0;
    o_val    = '0;
    o_pos    = '0;
    o_last   = 1'b0;
    unique case (state_r)
      hss_pkg::S_IDLE: begin
        if (in_acc && in_kind == hss_pkg::K_LOAD && ld_ok) begin
          st_we    = 1'b1;
          st_waddr = st_addr(EW'(in_load_entry), PW'(in_load_variable));
          st_wdata = in_load_value;
        end
        if (in_acc && in_kind == hss_pkg::K_IMPROVISE) begin
          st_re    = 1'b1;
          st_raddr = st_addr(pick_sat, bp_r);
        end
      end
      hss_pkg::S_LD_SUM: begin
        st_re    = (iss_r < KW'(NUM_VARIABLES));
        st_raddr = st_addr(ent_r, iss_r[PW-1:0]);
        pipe_re  = st_re;
      end
      hss_pkg::S_LD_OUT: begin
        out_load = out_free;
        ef_we    = out_free && ld_ok_r;
        o_kind   = hss_pkg::RK_LOAD;
        o_idx    = lde_r;
        o_fit    = ld_ok_r ? acc_r : '0;
        o_val    = val_r;
        o_pos    = ldp_r;
      end
      hss_pkg::S_IM_SQ: begin
        out_load = out_free;
        o_kind   = hss_pkg::RK_BUILT;
        o_val    = val_r;
        o_pos    = 3'(pos_r);
      end
      hss_pkg::S_SCAN, hss_pkg::S_QSCAN: begin
        ef_re    = (iss_r < KW'(NUM_HARMONIES));
        ef_raddr = iss_r[EW-1:0];
        pipe_re  = ef_re;
      end
      hss_pkg::S_COPY: begin
        st_we    = 1'b1;
        st_waddr = st_addr(best_idx_r, iss_r[PW-1:0]);
        st_wdata = nh_r[iss_r[PW-1:0]];
      end
      hss_pkg::S_FIN: begin
        out_load = out_free;
        ef_we    = out_free && found_r;
        ef_waddr = best_idx_r;
        ef_wdata = new_fit_r;
        o_kind   = hss_pkg::RK_FINISH;
        o_rep    = found_r;
        o_idx    = found_r ? 4'(best_idx_r) : 4'd0;
        o_fit    = new_fit_r;
      end
      hss_pkg::S_QRD: begin
        st_re    = 1'b1;
        st_raddr = st_addr(best_idx_r, iss_r[PW-1:0]);
      end
      hss_pkg::S_QOUT: begin
        out_load = out_free;
        o_kind   = hss_pkg::RK_BEST;
        o_idx    = 4'(best_idx_r);
        o_fit    = best_fit_r;
        o_val    = st_rdata_r;
        o_pos    = 3'(iss_r);
        o_last   = (iss_r == KW'(NUM_VARIABLES - 1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (st_re) st_rdata_r <= st_mem[st_raddr];
    if (ef_we) ef_mem[ef_waddr] <= ef_wdata;
    if (ef_re) ef_rdata_r <= ef_mem[ef_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hss_pkg::S_IDLE;
      cons_r      <= hss_pkg::CONSIDER_RATE_RST;
      pitch_r     <= hss_pkg::PITCH_RATE_RST;
      bp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          hss_pkg::CFG_CONSIDER: cons_r  <= cfg_data;
          hss_pkg::CFG_PITCH:    pitch_r <= cfg_data;
        endcase
      end
      if (state_r == hss_pkg::S_IM_ACC) begin
        bp_r <= pos_last ? '0 : PW'(pos_r + 1'b1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_v_r <= pipe_re;
    rd_k_r <= iss_r;
    unique case (state_r)
      hss_pkg::S_IDLE: begin
        if (in_acc) begin
          lde_r       <= in_load_entry;
          ldp_r       <= in_load_variable;
          ld_ok_r     <= ld_ok;
          ent_r       <= EW'(in_load_entry);
          val_r       <= in_load_value;
          pos_r       <= (in_kind == hss_pkg::K_LOAD) ? PW'(in_load_variable) : bp_r;
          use_mem_r   <= (in_consider_draw < cons_r);
          use_pitch_r <= (in_pitch_draw < pitch_r);
          fresh_r     <= in_fresh_value;
          step_r      <= in_pitch_step;
          iss_r       <= '0;
          acc_r       <= '0;
          acc_n_r     <= '0;
          sq_v_r      <= 1'b0;
        end
      end
      hss_pkg::S_LD_SUM: begin
        if (st_re) iss_r <= iss_r + 1'b1;
        if (rd_v_r) sq_r <= prod[SW-1:0];
        sq_v_r <= rd_v_r;
        if (sq_v_r) begin
          acc_r   <= fit_add(acc_r, sq_r);
          acc_n_r <= acc_n_r + 1'b1;
        end
      end
      hss_pkg::S_IM_VAL: begin
        val_r        <= use_pitch_r ? pitch_add(base_v, step_r) : base_v;
        nh_r[pos_r]  <= use_pitch_r ? pitch_add(base_v, step_r) : base_v;
      end
      hss_pkg::S_IM_SQ: sq_r <= prod[SW-1:0];
      hss_pkg::S_IM_ACC: begin
        new_fit_r <= fit_add((pos_r == '0) ? '0 : new_fit_r, sq_r);
        iss_r     <= '0;
        found_r   <= 1'b0;
      end
      hss_pkg::S_SCAN: begin
        if (scan_hit) begin
          best_idx_r <= rd_k_r[EW-1:0];
          found_r    <= 1'b1;
          iss_r      <= '0;
        end else if (ef_re) begin
          iss_r <= iss_r + 1'b1;
        end
      end
      hss_pkg::S_COPY: iss_r <= iss_r + 1'b1;
      hss_pkg::S_QSCAN: begin
        if (ef_re) iss_r <= iss_r + 1'b1;
        if (rd_v_r && (rd_k_r == '0 || ef_rdata_r < best_fit_r)) begin
          best_idx_r <= rd_k_r[EW-1:0];
          best_fit_r <= ef_rdata_r;
        end
        if (rd_v_r && rd_k_r == KW'(NUM_HARMONIES - 1)) iss_r <= '0;
      end
      hss_pkg::S_QOUT: if (out_free) iss_r <= iss_r + 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result_kind_r      <= o_kind;
      out_replaced_r         <= o_rep;
      out_entry_index_r      <= o_idx;
      out_fitness_r          <= o_fit;
      out_element_value_r    <= o_val;
      out_element_position_r <= o_pos;
      out_last_r             <= o_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_kind      = out_result_kind_r;
  assign out_replaced         = out_replaced_r;
  assign out_entry_index      = out_entry_index_r;
  assign out_fitness          = out_fitness_r;
  assign out_element_value    = out_element_value_r;
  assign out_element_position = out_element_position_r;
  assign out_last             = out_last_r;

  a_copy_target: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hss_pkg::S_COPY |-> found_r && (32'(best_idx_r) < NUM_HARMONIES))
    else $error("copy into an entry that was not found by the scan");

  a_build_pos: assert property (@(posedge clk) disable iff (!rst_n)
    32'(bp_r) < NUM_VARIABLES)
    else $error("build position out of range");

  a_imp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_kind == hss_pkg::K_IMPROVISE |=> !in_ready)
    else $error("improvise item did not occupy the engine");

  a_load_sum: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hss_pkg::S_LD_OUT |-> !ld_ok_r || acc_n_r == KW'(NUM_VARIABLES))
    else $error("load result issued before all squares were summed");

endmodule

// ===== tb/harmony_search_step_test.sv =====
// ----------------------------------------------------------------------------
// harmony_search_step_test
// Self-checking bench for the harmony search step engine. Fills the memory,
// drives directed load, improvise and query items, then random traffic under
// several rate settings with random stalls on both channels, and compares
// every result against an in-bench model of the memory and the build state.
// ----------------------------------------------------------------------------
module harmony_search_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NH        = hss_pkg::NUM_HARMONIES_DEF;
  localparam int NV        = hss_pkg::NUM_VARIABLES_DEF;
  localparam int LIMIT     = 500000;
  localparam int DRAIN     = 40;
  localparam int LONG_HOLD = 300;
  localparam int VAL_HI    = 32767;
  localparam int VAL_LO    = -32768;
  localparam int RND_HI    = 999;
  localparam int RND_LO    = -1000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef logic [NV-1:0][hss_pkg::VAL_W-1:0] harmony_t;
  typedef logic signed [hss_pkg::FIT_W:0] cmp_t;

  typedef struct {
    logic [1:0]                       kind;
    logic [3:0]                       le;
    logic [2:0]                       lv;
    logic signed [hss_pkg::VAL_W-1:0] lval;
    logic [15:0]                      cdraw;
    logic [3:0]                       pick;
    logic signed [hss_pkg::RND_W-1:0] fresh;
    logic [15:0]                      pdraw;
    logic signed [hss_pkg::RND_W-1:0] pstep;
  } stim_t;

  typedef struct {
    hss_pkg::rkind_t                  rk;
    logic                             rep;
    logic [3:0]                       idx;
    logic [hss_pkg::FIT_W-1:0]        fit;
    logic signed [hss_pkg::VAL_W-1:0] val;
    logic [2:0]                       pos;
    logic                             last;
    bit                               fit_known;
  } result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_kind = hss_pkg::K_LOAD;
  logic [3:0]              in_load_entry = '0;
  logic [2:0]              in_load_variable = '0;
  logic signed [15:0]      in_load_value = '0;
  logic [15:0]             in_consider_draw = '0;
  logic [3:0]              in_pick_entry = '0;
  logic signed [10:0]      in_fresh_value = '0;
  logic [15:0]             in_pitch_draw = '0;
  logic signed [10:0]      in_pitch_step = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              out_result_kind;
  logic                    out_replaced;
  logic [3:0]              out_entry_index;
  logic [32:0]             out_fitness;
  logic signed [15:0]      out_element_value;
  logic [2:0]              out_element_position;
  logic                    out_last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = hss_pkg::CFG_CONSIDER;
  logic [15:0]             cfg_data = '0;

  harmony_t                  mem_value [NH];
  logic [hss_pkg::FIT_W-1:0] mem_fit [NH];
  bit [NV-1:0]               row_loaded [NH];
  harmony_t                  new_harmony;
  int                        build_pos = 0;
  logic [hss_pkg::RATE_W-1:0] consider_thr = hss_pkg::CONSIDER_RATE_RST;
  logic [hss_pkg::RATE_W-1:0] pitch_thr = hss_pkg::PITCH_RATE_RST;
  result_t                   results_due [$];

  int errors = 0;
  int checked = 0;
  int replacements = 0;
  int n_load = 0;
  int n_improv = 0;
  int n_query = 0;
  int n_unused = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit long_hold = 1'b0;

  harmony_search_step u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still due", LIMIT, results_due.size());
    $display("[harmony_search_step] ERROR");
    $finish;
  end

  function automatic logic [hss_pkg::FIT_W-1:0] sum_of_squares(harmony_t h);
    longint acc;
    longint x;
    acc = 0;
    for (int i = 0; i < NV; i++) begin
      x = longint'($signed(h[i]));
      acc += x * x;
      if (acc > longint'(hss_pkg::FIT_MAX)) acc = longint'(hss_pkg::FIT_MAX);
    end
    return acc[hss_pkg::FIT_W-1:0];
  endfunction

  function automatic result_t make_result(hss_pkg::rkind_t rk, logic rep, logic [3:0] idx,
                                          logic [hss_pkg::FIT_W-1:0] fit,
                                          logic signed [hss_pkg::VAL_W-1:0] val,
                                          logic [2:0] pos, logic last, bit known);
    result_t r;
    r.rk = rk;
    r.rep = rep;
    r.idx = idx;
    r.fit = fit;
    r.val = val;
    r.pos = pos;
    r.last = last;
    r.fit_known = known;
    return r;
  endfunction

  task automatic step_harmony(stim_t s);
    int                        e;
    int                        p;
    int                        best;
    longint                    v;
    logic [hss_pkg::FIT_W-1:0] fit;
    logic                      rep;
    logic [3:0]                idx;
    bit                        known;
    case (s.kind)
      hss_pkg::K_LOAD: begin
        n_load++;
        fit = '0;
        known = 1'b1;
        if (s.le < NH && s.lv < NV) begin
          mem_value[s.le][s.lv] = s.lval;
          row_loaded[s.le][s.lv] = 1'b1;
          mem_fit[s.le] = sum_of_squares(mem_value[s.le]);
          fit = mem_fit[s.le];
          known = &row_loaded[s.le];
        end
        results_due.push_back(make_result(hss_pkg::RK_LOAD, 1'b0, s.le, fit, s.lval, s.lv,
                                          1'b0, known));
      end
      hss_pkg::K_IMPROVISE: begin
        n_improv++;
        p = (build_pos >= NV) ? 0 : build_pos;
        if (s.cdraw < consider_thr) begin
          e = (s.pick >= NH) ? NH - 1 : int'(s.pick);
          v = longint'($signed(mem_value[e][p]));
        end else begin
          v = longint'(s.fresh);
        end
        if (s.pdraw < pitch_thr) begin
          v += longint'(s.pstep);
          if (v > VAL_HI) v = VAL_HI;
          if (v < VAL_LO) v = VAL_LO;
        end
        new_harmony[p] = v[hss_pkg::VAL_W-1:0];
        results_due.push_back(make_result(hss_pkg::RK_BUILT, 1'b0, '0, '0,
                                          v[hss_pkg::VAL_W-1:0], p[2:0], 1'b0, 1'b1));
        if (p + 1 >= NV) begin
          fit = sum_of_squares(new_harmony);
          rep = 1'b0;
          idx = '0;
          for (int i = 0; i < NH; i++) begin
            if (!rep && fit < mem_fit[i]) begin
              mem_value[i] = new_harmony;
              mem_fit[i] = fit;
              rep = 1'b1;
              idx = 4'(i);
            end
          end
          if (rep) replacements++;
          results_due.push_back(make_result(hss_pkg::RK_FINISH, rep, idx, fit, '0, '0, 1'b0,
                                            1'b1));
          build_pos = 0;
        end else begin
          build_pos = p + 1;
        end
      end
      hss_pkg::K_QUERY: begin
        n_query++;
        best = 0;
        for (int i = 1; i < NH; i++)
          if (mem_fit[i] < mem_fit[best]) best = i;
        for (int i = 0; i < NV; i++)
          results_due.push_back(make_result(hss_pkg::RK_BEST, 1'b0, 4'(best), mem_fit[best],
                                            mem_value[best][i], 3'(i), i == NV - 1, 1'b1));
      end
      default: begin
        n_unused++;
      end
    endcase
  endtask

  task automatic check_field(string name, cmp_t want, cmp_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic take_result();
    result_t r;
    if (results_due.size() == 0) begin
      $error("result with nothing due: kind %0d, value %0d", out_result_kind,
             out_element_value);
      errors++;
    end else begin
      r = results_due.pop_front();
      checked++;
      check_field("result_kind", cmp_t'(r.rk), cmp_t'(out_result_kind));
      check_field("replaced", cmp_t'(r.rep), cmp_t'(out_replaced));
      check_field("entry_index", cmp_t'(r.idx), cmp_t'(out_entry_index));
      if (r.fit_known) check_field("fitness", cmp_t'(r.fit), cmp_t'(out_fitness));
      check_field("element_value", cmp_t'(r.val), cmp_t'(out_element_value));
      check_field("element_position", cmp_t'(r.pos), cmp_t'(out_element_position));
      check_field("last", cmp_t'(r.last), cmp_t'(out_last));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      step_harmony('{in_kind, in_load_entry, in_load_variable, in_load_value,
                     in_consider_draw, in_pick_entry, in_fresh_value, in_pitch_draw,
                     in_pitch_step});
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == hss_pkg::CFG_CONSIDER) consider_thr = cfg_data;
      else pitch_thr = cfg_data;
    end
    if (rst_n && out_valid && out_ready) take_result();
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic int rnd_small();
    return int'($urandom_range(0, RND_HI - RND_LO)) + RND_LO;
  endfunction

  function automatic stim_t noise_item();
    stim_t s;
    s.kind = 2'($urandom_range(0, 3));
    s.le = 4'($urandom_range(0, 15));
    s.lv = 3'($urandom_range(0, 7));
    s.lval = 16'($urandom_range(0, 65535));
    s.cdraw = 16'($urandom_range(0, 65535));
    s.pick = 4'($urandom_range(0, 15));
    s.fresh = 11'(rnd_small());
    s.pdraw = 16'($urandom_range(0, 65535));
    s.pstep = 11'(rnd_small());
    return s;
  endfunction

  function automatic stim_t load_item(int e, int v, int val);
    stim_t s;
    s = noise_item();
    s.kind = hss_pkg::K_LOAD;
    s.le = 4'(e);
    s.lv = 3'(v);
    s.lval = 16'(val);
    return s;
  endfunction

  function automatic stim_t improv_item(int cdraw, int pick, int fresh, int pdraw, int step);
    stim_t s;
    s = noise_item();
    s.kind = hss_pkg::K_IMPROVISE;
    s.cdraw = 16'(cdraw);
    s.pick = 4'(pick);
    s.fresh = 11'(fresh);
    s.pdraw = 16'(pdraw);
    s.pstep = 11'(step);
    return s;
  endfunction

  function automatic stim_t query_item();
    stim_t s;
    s = noise_item();
    s.kind = hss_pkg::K_QUERY;
    return s;
  endfunction

  function automatic stim_t random_item();
    stim_t s;
    int    roll;
    int    e;
    int    v;
    int    val;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      s = improv_item($urandom_range(0, 65535),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(NH, 15)
                                                  : $urandom_range(0, NH - 1),
                      rnd_small(), $urandom_range(0, 65535), rnd_small());
    end else if (roll < 82) begin
      e = $urandom_range(0, NH - 1);
      v = $urandom_range(0, NV - 1);
      val = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535)) : rnd_small();
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) e = $urandom_range(NH, 15);
        else v = $urandom_range(NV, 7);
      end
      s = load_item(e, v, val);
    end else if (roll < 95) begin
      s = query_item();
    end else begin
      s = noise_item();
      s.kind = KIND_UNUSED;
    end
    return s;
  endfunction

  task automatic send_item(stim_t s);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= s.kind;
    in_load_entry <= s.le;
    in_load_variable <= s.lv;
    in_load_value <= s.lval;
    in_consider_draw <= s.cdraw;
    in_pick_entry <= s.pick;
    in_fresh_value <= s.fresh;
    in_pitch_draw <= s.pdraw;
    in_pitch_step <= s.pstep;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_rates(logic [15:0] consider, logic [15:0] pitch);
    cfg_valid <= 1'b1;
    cfg_index <= hss_pkg::CFG_CONSIDER;
    cfg_data <= consider;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_index <= hss_pkg::CFG_PITCH;
    cfg_data <= pitch;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_fill_memory();
    for (int e = 0; e < NH; e++)
      for (int v = 0; v < NV; v++)
        send_item(load_item(e, v, rnd_small()));
    settle();
  endtask

  task automatic test_load_edges();
    send_item(load_item(NH - 1, 0, VAL_HI));
    send_item(load_item(NH - 1, 1, VAL_LO));
    send_item(load_item(NH - 1, 2, VAL_HI));
    send_item(load_item(NH - 1, 3, VAL_LO));
    send_item(load_item(NH - 1, 4, VAL_HI));
    send_item(load_item(12, 2, rnd_small()));
    send_item(load_item(3, 6, VAL_LO));
    send_item(load_item(15, 7, VAL_HI));
    settle();
  endtask

  task automatic test_improvise_directed();
    // copy the extreme entry back with saturating steps: equal fitness, no replacement
    send_item(improv_item(0, 15, 0, 0, RND_HI));
    send_item(improv_item(0, NH - 1, 0, 0, RND_LO));
    send_item(improv_item(0, NH, 0, int'(hss_pkg::PITCH_RATE_RST), RND_HI));
    send_item(improv_item(0, NH - 1, 0, 65535, 0));
    send_item(improv_item(int'(hss_pkg::CONSIDER_RATE_RST) - 1, NH - 1, 0,
                          int'(hss_pkg::PITCH_RATE_RST) - 1, 0));
    // two all-zero harmonies replace the first two entries, then tie on query
    repeat (2) begin
      send_item(improv_item(int'(hss_pkg::CONSIDER_RATE_RST), 0, 0, 65535, RND_HI));
      repeat (NV - 1) send_item(improv_item(65535, NH - 1, 0, int'(hss_pkg::PITCH_RATE_RST),
                                            RND_LO));
    end
    send_item(query_item());
    send_item(load_item(NH, NV, 0));
    begin
      stim_t s;
      s = noise_item();
      s.kind = KIND_UNUSED;
      send_item(s);
    end
    send_item(query_item());
    settle();
  endtask

  task automatic test_rate_sweep();
    logic [15:0] rates [4][2];
    rates = '{'{16'd0, 16'hFFFF}, '{16'hFFFF, 16'd0},
              '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))},
              '{hss_pkg::CONSIDER_RATE_RST, hss_pkg::PITCH_RATE_RST}};
    for (int k = 0; k < 4; k++) begin
      write_rates(rates[k][0], rates[k][1]);
      repeat (60) send_item(random_item());
      settle();
    end
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 20; i++)
      send_item((i % 3 == 0) ? query_item() : random_item());
    settle();
  endtask

  task automatic test_calm();
    calm = 1'b1;
    repeat (40) send_item(random_item());
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_memory();
    test_load_edges();
    test_improvise_directed();
    test_rate_sweep();
    test_backpressure();
    test_calm();
    $display("covered %0d loads, %0d improvise, %0d queries, %0d ignored items",
             n_load, n_improv, n_query, n_unused);
    $display("%0d results checked, %0d replacements, rates swept to both extremes",
             checked, replacements);
    if (errors == 0) begin
      $display("[harmony_search_step] OK");
    end else begin
      $display("[harmony_search_step] ERROR");
    end
    $finish;
  end

endmodule
